FILE: hw/rtl/ksw_pkg.sv
`timescale 1ns / 1ps

package ksw_pkg;

    // window storage geometry
    localparam int WINDOW_DEPTH = 16;
    localparam int VALUE_WIDTH  = 32;
    localparam int IDX_W        = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = IDX_W + 1;

    // configuration register map
    localparam int K_WIDTH      = 4;
    localparam int APB_AW       = 3;
    localparam int APB_DW       = 32;
    localparam logic [K_WIDTH-1:0] K_RESET = K_WIDTH'(2);
    localparam logic REG_WINDOW_K = 1'b0;

    // input item
    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] value_in;
        logic                          is_final;
    } item_t;

    // result item
    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] value_out;
        logic                          is_last_out;
    } result_t;

endpackage

FILE: hw/rtl/k_sorted_window_heap_sorter.sv
`timescale 1ns / 1ps

// Sorts a stream in which every value lies at most window_k places from its
// sorted position. Values sit in a 16-entry synchronous window memory with
// one read port and one write port. Each accepted item is written into the
// window; when the window then holds more than window_k values (or is full)
// the smallest is found by reading the held entries one per cycle, emitted,
// and its slot refilled with the last held entry. On an item flagged
// is_final the whole window drains in ascending order, and the last result
// carries is_last_out. window_k (APB address 0, reset 2) may only be written
// while the block is idle.
module k_sorted_window_heap_sorter (
    input  logic                              clk,
    input  logic                              rst_n,
    // apb configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ksw_pkg::APB_AW-1:0]        paddr,
    input  logic [ksw_pkg::APB_DW-1:0]        pwdata,
    output logic [ksw_pkg::APB_DW-1:0]        prdata,
    output logic                              pready,
    // input items
    input  logic                              item_valid,
    output logic                              item_ready,
    input  ksw_pkg::item_t                    item,
    // result items
    output logic                              result_valid,
    input  logic                              result_ready,
    output ksw_pkg::result_t                  result
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]                          state_reg, state_next;
    logic [ksw_pkg::CNT_W-1:0]           count_reg, count_next;
    logic [ksw_pkg::K_WIDTH-1:0]         k_reg, k_next;
    logic                                fin_reg, fin_next;
    logic [ksw_pkg::CNT_W-1:0]           rd_idx_reg, rd_idx_next;
    logic                                rd_pend_reg, rd_pend_next;
    logic [ksw_pkg::IDX_W-1:0]           rd_tag_reg, rd_tag_next;
    logic signed [ksw_pkg::VALUE_WIDTH-1:0] best_val_reg, best_val_next;
    logic [ksw_pkg::IDX_W-1:0]           best_idx_reg, best_idx_next;
    logic [ksw_pkg::VALUE_WIDTH-1:0]     last_val_reg, last_val_next;
    logic                                out_valid_reg, out_valid_next;
    ksw_pkg::result_t                    out_data_reg, out_data_next;

    // window memory
    logic [ksw_pkg::VALUE_WIDTH-1:0]     mem [ksw_pkg::WINDOW_DEPTH];
    logic [ksw_pkg::VALUE_WIDTH-1:0]     mem_rdata_reg;
    logic                                mem_re;
    logic [ksw_pkg::IDX_W-1:0]           mem_raddr;
    logic                                mem_we;
    logic [ksw_pkg::IDX_W-1:0]           mem_waddr;
    logic [ksw_pkg::VALUE_WIDTH-1:0]     mem_wdata;

    logic                                item_xfer;
    logic                                cfg_write;
    logic                                out_free;

    assign pready       = 1'b1;
    assign item_ready   = (state_reg == ST_IDLE);
    assign item_xfer    = item_valid && item_ready;
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;
    assign out_free     = !out_valid_reg || result_ready;
    assign cfg_write    = psel && penable && pwrite && pready;

    // register read
    always_comb
    begin
        if (paddr[2] == ksw_pkg::REG_WINDOW_K)
        begin
            prdata = ksw_pkg::APB_DW'(k_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    // memory ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    // sequencer: insert, scan for minimum, emit and refill
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        fin_next       = fin_reg;
        rd_idx_next    = rd_idx_reg;
        rd_pend_next   = rd_pend_reg;
        rd_tag_next    = rd_tag_reg;
        best_val_next  = best_val_reg;
        best_idx_next  = best_idx_reg;
        last_val_next  = last_val_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mem_re         = 1'b0;
        mem_raddr      = rd_idx_reg[ksw_pkg::IDX_W-1:0];
        mem_we         = 1'b0;
        mem_waddr      = count_reg[ksw_pkg::IDX_W-1:0];
        mem_wdata      = item.value_in;

        // configuration write
        if (cfg_write && paddr[2] == ksw_pkg::REG_WINDOW_K)
        begin
            k_next = pwdata[ksw_pkg::K_WIDTH-1:0];
        end

        // result transfer frees the output register
        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                // insert the new value at the end of the window
                if (item_xfer)
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + ksw_pkg::CNT_W'(1);
                    fin_next   = item.is_final;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                rd_idx_next  = '0;
                rd_pend_next = 1'b0;
                if (fin_reg || count_reg > ksw_pkg::CNT_W'(k_reg)
                    || count_reg[ksw_pkg::CNT_W-1])
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                // issue one read per cycle over the held entries
                if (rd_idx_reg < count_reg)
                begin
                    mem_re       = 1'b1;
                    rd_idx_next  = rd_idx_reg + ksw_pkg::CNT_W'(1);
                    rd_pend_next = 1'b1;
                    rd_tag_next  = rd_idx_reg[ksw_pkg::IDX_W-1:0];
                end
                else
                begin
                    rd_pend_next = 1'b0;
                end
                // compare returning data against the running minimum
                if (rd_pend_reg)
                begin
                    if (rd_tag_reg == '0
                        || $signed(mem_rdata_reg) < best_val_reg)
                    begin
                        best_val_next = $signed(mem_rdata_reg);
                        best_idx_next = rd_tag_reg;
                    end
                    if ({1'b0, rd_tag_reg} == count_reg - ksw_pkg::CNT_W'(1))
                    begin
                        last_val_next = mem_rdata_reg;
                        state_next    = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                // emit the minimum and move the last entry into its slot
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.value_out   = best_val_reg;
                    out_data_next.is_last_out = fin_reg
                                                && count_reg == ksw_pkg::CNT_W'(1);
                    mem_we       = 1'b1;
                    mem_waddr    = best_idx_reg;
                    mem_wdata    = last_val_reg;
                    count_next   = count_reg - ksw_pkg::CNT_W'(1);
                    rd_idx_next  = '0;
                    rd_pend_next = 1'b0;
                    if (fin_reg && count_reg > ksw_pkg::CNT_W'(1))
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            k_reg         <= ksw_pkg::K_RESET;
            fin_reg       <= 1'b0;
            rd_idx_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            k_reg         <= k_next;
            fin_reg       <= fin_next;
            rd_idx_reg    <= rd_idx_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_tag_reg   <= rd_tag_next;
        best_val_reg <= best_val_next;
        best_idx_reg <= best_idx_next;
        last_val_reg <= last_val_next;
        out_data_reg <= out_data_next;
    end

endmodule
